@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define PKMSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PKMSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pkmsu_pkg.sv @@
// types, codes and lookup tables of the pressure key scanner
// no dependencies; used by every design module of the block
package pkmsu_pkg;

    localparam int NUM_KEYS = 16;
    localparam int KEY_W    = 4;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [2:0] {
        MSG_NONE     = 3'd0,
        MSG_NOTE_ON  = 3'd1,
        MSG_PRESSURE = 3'd2,
        MSG_NOTE_OFF = 3'd3,
        MSG_CC       = 3'd4
    } msg_kind_t;

    typedef enum logic [2:0] {
        LED_NONE     = 3'd0,
        LED_OFF      = 3'd1,
        LED_BLUE     = 3'd2,
        LED_ORANGE   = 3'd3,
        LED_RED      = 3'd4,
        LED_GRADIENT = 3'd5
    } led_act_t;

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_SCAN      = 1'b1;

    localparam logic [1:0] REG_TRIG   = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_SMOOTH = 2'd2;

    localparam logic [11:0] TRIG_RESET   = 12'd100;
    localparam logic [7:0]  STEP_RESET   = 8'd0;
    localparam logic [8:0]  SMOOTH_RESET = 9'd32;

    localparam key_t KEY_CTRL_MOD    = 4'd6;
    localparam key_t KEY_OCT_UP      = 4'd7;
    localparam key_t KEY_OCT_DOWN    = 4'd14;
    localparam key_t KEY_CTRL_BREATH = 4'd15;

    localparam logic [6:0] CC_MOD    = 7'd16;
    localparam logic [6:0] CC_BREATH = 7'd1;
    localparam logic [6:0] VAL_MAX   = 7'd127;

    // velocity scale factors in Q8
    localparam int VEL_SCALE_Q8  = 218;
    localparam int TRIG_SCALE_Q8 = 650;

    localparam logic signed [6:0] OCT_STEP = 7'sd12;
    localparam logic signed [6:0] OCT_MAX  = 7'sd24;
    localparam logic signed [6:0] OCT_MIN  = -7'sd24;

    // per-key state kept in the key memory (rest level lives beside it)
    typedef struct packed {
        logic              held;
        logic              armed;
        logic [6:0]        start_vel;
        logic [14:0]       smooth;
        logic signed [6:0] octave;
    } key_state_t;

    typedef struct packed {
        msg_kind_t  kind;
        logic [6:0] number;
        logic [6:0] value;
        logic [3:0] led_idx;
        led_act_t   led_act;
        logic [7:0] green;
    } result_t;

    typedef struct packed {
        logic rd;
        logic wr;
        key_t addr;
    } mem_ctl_t;

    typedef struct packed {
        logic [1:0]        count;
        logic [4:0]        active;
        logic signed [6:0] octave;
    } dec_t;

    function automatic logic [6:0] pitch_of(input key_t k);
        logic [6:0] p;
        unique case (k)
            4'd0:  p = 7'd43;
            4'd1:  p = 7'd42;
            4'd2:  p = 7'd45;
            4'd3:  p = 7'd44;
            4'd4:  p = 7'd47;
            4'd5:  p = 7'd46;
            4'd6:  p = 7'd95;
            4'd7:  p = 7'd95;
            4'd8:  p = 7'd41;
            4'd9:  p = 7'd40;
            4'd10: p = 7'd39;
            4'd11: p = 7'd38;
            4'd12: p = 7'd37;
            4'd13: p = 7'd36;
            4'd14: p = 7'd95;
            4'd15: p = 7'd95;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] led_of(input key_t k);
        logic [3:0] l;
        unique case (k)
            4'd0:  l = 4'd6;
            4'd1:  l = 4'd7;
            4'd2:  l = 4'd4;
            4'd3:  l = 4'd5;
            4'd4:  l = 4'd3;
            4'd5:  l = 4'd2;
            4'd6:  l = 4'd0;
            4'd7:  l = 4'd1;
            4'd8:  l = 4'd14;
            4'd9:  l = 4'd15;
            4'd10: l = 4'd12;
            4'd11: l = 4'd13;
            4'd12: l = 4'd11;
            4'd13: l = 4'd10;
            4'd14: l = 4'd9;
            4'd15: l = 4'd8;
        endcase
        return l;
    endfunction

    // control and octave keys come out of reset already armed
    function automatic key_state_t reset_state(input key_t k);
        key_state_t s;
        s       = '0;
        s.armed = (k == KEY_CTRL_MOD) || (k == KEY_OCT_UP) ||
                  (k == KEY_OCT_DOWN) || (k == KEY_CTRL_BREATH);
        return s;
    endfunction

endpackage

@@ hdl/pkmsu_state_mem.sv @@
// per-key state memory: rest levels and key state, registered read
// depends on pkmsu_pkg
module pkmsu_state_mem #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pkmsu_pkg::mem_ctl_t       ctl,
    input  logic [SAMPLE_BITS-1:0]    wr_rest,
    input  pkmsu_pkg::key_state_t     wr_state,
    output logic [SAMPLE_BITS-1:0]    rd_rest,
    output pkmsu_pkg::key_state_t     rd_state
);

    logic [SAMPLE_BITS-1:0]   rest_mem  [pkmsu_pkg::NUM_KEYS];
    pkmsu_pkg::key_state_t    state_mem [pkmsu_pkg::NUM_KEYS];
    logic [pkmsu_pkg::NUM_KEYS-1:0] valid_reg;

    logic [SAMPLE_BITS-1:0]   rest_q_reg;
    pkmsu_pkg::key_state_t    state_q_reg;
    logic                     hit_q_reg;
    pkmsu_pkg::key_t          key_q_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            rest_mem[ctl.addr]  <= wr_rest;
            state_mem[ctl.addr] <= wr_state;
        end
        if (ctl.rd) begin
            rest_q_reg  <= rest_mem[ctl.addr];
            state_q_reg <= state_mem[ctl.addr];
            hit_q_reg   <= valid_reg[ctl.addr];
            key_q_reg   <= ctl.addr;
        end
    end

    // an entry never written reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.wr) begin
            valid_reg[ctl.addr] <= 1'b1;
        end
    end

    assign rd_rest  = hit_q_reg ? rest_q_reg : '0;
    assign rd_state = hit_q_reg ? state_q_reg : pkmsu_pkg::reset_state(key_q_reg);

endmodule

@@ hdl/pkmsu_key_proc.sv @@
// key datapath: threshold and velocity stage, then per-key decision
// depends on pkmsu_pkg
module pkmsu_key_proc #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      calc_en,
    input  logic                      opcode,
    input  pkmsu_pkg::key_t           key,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic [SAMPLE_BITS-1:0]    rest,
    input  pkmsu_pkg::key_state_t     st,
    input  logic [11:0]               trig,
    input  logic [7:0]                step,
    input  logic [8:0]                smooth_f,
    input  logic [4:0]                active,
    input  logic signed [6:0]         octave,
    output logic [SAMPLE_BITS-1:0]    wr_rest,
    output pkmsu_pkg::key_state_t     wr_state,
    output pkmsu_pkg::result_t        res0,
    output pkmsu_pkg::result_t        res1,
    output pkmsu_pkg::dec_t           dec
);

    localparam int THR_W  = ((SAMPLE_BITS > 13) ? SAMPLE_BITS : 13) + 2;
    localparam int PROD_W = SAMPLE_BITS + 8;

    function automatic pkmsu_pkg::result_t mk(
        input pkmsu_pkg::msg_kind_t k,
        input logic [6:0]           num,
        input logic [6:0]           val,
        input logic [3:0]           li,
        input pkmsu_pkg::led_act_t  act,
        input logic [7:0]           g
    );
        pkmsu_pkg::result_t r;
        r.kind    = k;
        r.number  = num;
        r.value   = val;
        r.led_idx = li;
        r.led_act = act;
        r.green   = g;
        return r;
    endfunction

    // stage one: threshold, compare, velocity
    logic [12:0]             step_sum;
    logic [THR_W-1:0]        thr;
    logic                    above;
    logic [SAMPLE_BITS-1:0]  rise;
    logic [PROD_W-1:0]       vel_prod;
    logic [SAMPLE_BITS-1:0]  vel_full;
    logic [6:0]              vel;

    logic                    above_reg;
    logic [6:0]              vel_reg;

    assign step_sum = {8'd0, active} * {5'd0, step};
    assign thr      = THR_W'(rest) + THR_W'(trig) + THR_W'(step_sum);
    assign above    = THR_W'(sample) > thr;
    assign rise     = sample - thr[SAMPLE_BITS-1:0];
    assign vel_prod = PROD_W'(rise) * PROD_W'(pkmsu_pkg::VEL_SCALE_Q8);
    assign vel_full = vel_prod[PROD_W-1:8];
    assign vel      = (vel_full > SAMPLE_BITS'(pkmsu_pkg::VAL_MAX)) ?
                      pkmsu_pkg::VAL_MAX : vel_full[6:0];

    always_ff @(posedge aclk) begin
        if (calc_en) begin
            above_reg <= above;
            vel_reg   <= vel;
        end
    end

    // stage two: trigger velocity and smoothing
    logic [6:0]          tv_d;
    logic [16:0]         tv_prod;
    logic [8:0]          tv_full;
    logic [6:0]          tv;
    logic signed [16:0]  s_delta;
    logic signed [26:0]  s_prod;
    logic signed [18:0]  s_stepv;
    logic signed [19:0]  s_sum;
    logic [14:0]         s_new;

    assign tv_d    = vel_reg - st.start_vel;
    assign tv_prod = 17'(tv_d) * 17'(pkmsu_pkg::TRIG_SCALE_Q8);
    assign tv_full = tv_prod[16:8];
    assign tv      = (vel_reg <= st.start_vel) ? 7'd0 :
                     (tv_full > 9'(pkmsu_pkg::VAL_MAX)) ? pkmsu_pkg::VAL_MAX : tv_full[6:0];

    // arithmetic shift gives the floored step for both signs
    assign s_delta = $signed({2'b00, vel_reg, 8'd0}) - $signed({2'b00, st.smooth});
    assign s_prod  = 27'($signed({1'b0, smooth_f})) * 27'(s_delta);
    assign s_stepv = 19'(s_prod >>> 8);
    assign s_sum   = $signed({5'd0, st.smooth}) + 20'(s_stepv);
    assign s_new   = (s_sum < 20'sd0) ? 15'd0 :
                     (s_sum > 20'sd32767) ? 15'h7fff : s_sum[14:0];

    logic               is_ctrl;
    logic               is_oct;
    logic [6:0]         cc_num;
    logic [3:0]         led;
    logic [6:0]         note_now;
    logic [6:0]         note_held;
    logic [4:0]         act_up;
    logic [4:0]         act_dn;
    logic               oct_move;
    logic signed [6:0]  oct_new;

    assign is_ctrl   = (key == pkmsu_pkg::KEY_CTRL_MOD) || (key == pkmsu_pkg::KEY_CTRL_BREATH);
    assign is_oct    = (key == pkmsu_pkg::KEY_OCT_UP) || (key == pkmsu_pkg::KEY_OCT_DOWN);
    assign cc_num    = (key == pkmsu_pkg::KEY_CTRL_MOD) ? pkmsu_pkg::CC_MOD : pkmsu_pkg::CC_BREATH;
    assign led       = pkmsu_pkg::led_of(key);
    // a released key always sits at the current octave, a held one keeps its own
    assign note_now  = pkmsu_pkg::pitch_of(key) + octave[6:0];
    assign note_held = pkmsu_pkg::pitch_of(key) + st.octave[6:0];
    assign act_up    = (active != 5'd31) ? active + 5'd1 : active;
    assign act_dn    = (active != 5'd0) ? active - 5'd1 : active;
    assign oct_move  = (key == pkmsu_pkg::KEY_OCT_DOWN) ? (octave > pkmsu_pkg::OCT_MIN) :
                                                          (octave < pkmsu_pkg::OCT_MAX);
    assign oct_new   = (key == pkmsu_pkg::KEY_OCT_DOWN) ? octave - pkmsu_pkg::OCT_STEP :
                                                          octave + pkmsu_pkg::OCT_STEP;

    always_comb begin
        wr_rest    = rest;
        wr_state   = st;
        res0       = '0;
        res1       = '0;
        dec.count  = 2'd0;
        dec.active = active;
        dec.octave = octave;
        if (opcode == pkmsu_pkg::OP_CALIBRATE) begin
            wr_rest = sample;
        end else if (above_reg) begin
            if (!st.held) begin
                if (!st.armed) begin
                    wr_state.start_vel = vel_reg;
                    wr_state.armed     = 1'b1;
                end else if (is_oct) begin
                    wr_state.held = 1'b1;
                    if (oct_move) begin
                        dec.octave = oct_new;
                        dec.count  = 2'd1;
                        if (oct_new == 7'sd0) begin
                            dec.count = 2'd2;
                            res0 = mk(pkmsu_pkg::MSG_NONE, 7'd0, 7'd0,
                                      pkmsu_pkg::led_of(pkmsu_pkg::KEY_OCT_DOWN),
                                      pkmsu_pkg::LED_OFF, 8'd0);
                            res1 = mk(pkmsu_pkg::MSG_NONE, 7'd0, 7'd0,
                                      pkmsu_pkg::led_of(pkmsu_pkg::KEY_OCT_UP),
                                      pkmsu_pkg::LED_OFF, 8'd0);
                        end else if (oct_new < 7'sd0) begin
                            res0 = mk(pkmsu_pkg::MSG_NONE, 7'd0, 7'd0,
                                      pkmsu_pkg::led_of(pkmsu_pkg::KEY_OCT_DOWN),
                                      (oct_new == pkmsu_pkg::OCT_MIN) ? pkmsu_pkg::LED_RED :
                                                                        pkmsu_pkg::LED_ORANGE,
                                      8'd0);
                        end else begin
                            res0 = mk(pkmsu_pkg::MSG_NONE, 7'd0, 7'd0,
                                      pkmsu_pkg::led_of(pkmsu_pkg::KEY_OCT_UP),
                                      (oct_new == pkmsu_pkg::OCT_MAX) ? pkmsu_pkg::LED_RED :
                                                                        pkmsu_pkg::LED_ORANGE,
                                      8'd0);
                        end
                    end
                end else if (is_ctrl) begin
                    wr_state.held   = 1'b1;
                    wr_state.smooth = {vel_reg, 8'd0};
                    dec.active      = act_up;
                    dec.count       = 2'd1;
                    res0 = mk(pkmsu_pkg::MSG_CC, cc_num, vel_reg, led,
                              pkmsu_pkg::LED_GRADIENT, {vel_reg, 1'b0});
                end else begin
                    wr_state.held   = 1'b1;
                    wr_state.smooth = {tv, 8'd0};
                    wr_state.octave = octave;
                    dec.active      = act_up;
                    dec.count       = 2'd1;
                    res0 = mk(pkmsu_pkg::MSG_NOTE_ON, note_now, tv, led,
                              pkmsu_pkg::LED_BLUE, 8'd0);
                end
            end else if (is_ctrl) begin
                wr_state.smooth = s_new;
                dec.count       = 2'd1;
                res0 = mk(pkmsu_pkg::MSG_CC, cc_num, s_new[14:8], led,
                          pkmsu_pkg::LED_GRADIENT, s_new[14:7]);
            end else if (!is_oct) begin
                wr_state.smooth = s_new;
                dec.count       = 2'd1;
                res0 = mk(pkmsu_pkg::MSG_PRESSURE, note_held, s_new[14:8], 4'd0,
                          pkmsu_pkg::LED_NONE, 8'd0);
            end
        end else if (st.held) begin
            wr_state.held = 1'b0;
            if (is_ctrl) begin
                dec.active = act_dn;
                dec.count  = 2'd1;
                res0 = mk(pkmsu_pkg::MSG_CC, cc_num, 7'd0, led, pkmsu_pkg::LED_OFF, 8'd0);
            end else if (!is_oct) begin
                wr_state.armed = 1'b0;
                dec.active     = act_dn;
                dec.count      = 2'd1;
                res0 = mk(pkmsu_pkg::MSG_NOTE_OFF, note_held, pkmsu_pkg::VAL_MAX, led,
                          pkmsu_pkg::LED_OFF, 8'd0);
            end
        end
    end

endmodule

@@ hdl/pkmsu_out_q.sv @@
// two-slot result queue in front of the output channel
// depends on pkmsu_pkg
module pkmsu_out_q (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [1:0]            count,
    input  pkmsu_pkg::result_t    r0,
    input  pkmsu_pkg::result_t    r1,
    input  logic                  pop,
    output logic                  valid,
    output pkmsu_pkg::result_t    head,
    output logic                  head_last
);

    logic [1:0]          cnt_reg;
    pkmsu_pkg::result_t  slot0_reg;
    pkmsu_pkg::result_t  slot1_reg;
    logic                last0_reg;
    logic                last1_reg;

    assign valid     = (cnt_reg != 2'd0);
    assign head      = slot0_reg;
    assign head_last = last0_reg;

    // push only happens into an empty queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (push) begin
            cnt_reg <= count;
        end else if (valid && pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot0_reg <= r0;
            slot1_reg <= r1;
            last0_reg <= (count == 2'd1);
            last1_reg <= 1'b1;
        end else if (valid && pop) begin
            slot0_reg <= slot1_reg;
            last0_reg <= last1_reg;
        end
    end

endmodule

@@ hdl/pressure_key_midi_scanner_unit.sv @@
// top level of the pressure key scanner: sequencer, config registers, channels
// depends on pkmsu_pkg, pkmsu_state_mem, pkmsu_key_proc, pkmsu_out_q
//
// channel   | direction | handshake                 | contents
// ----------+-----------+---------------------------+---------------------------------
// s_axis    | in        | tvalid/tready             | one key sample: calibrate or scan
// m_axis    | out       | tvalid/tready, tlast      | message and led code, 0..2 per item
// apb       | in        | psel/penable/pwrite/pready| trigger, step, smooth registers
//
// each item passes in turn through accept, memory read, threshold/velocity, decide and write back
// the per-key memory read-modify-write keeps one item in flight at a time
// results go to a two-slot queue, so the next item is taken while results wait
// decide stalls only while the queue still holds the previous item's results
// synchronous active-low reset; per-key state is valid at once through entry valid bits
module pressure_key_midi_scanner_unit #(
    parameter  int SAMPLE_BITS = 12,
    localparam int S_DATA_W    = ((pkmsu_pkg::KEY_W + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input transfers
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,   // key, sample, zero fill
    input  logic [0:0]           s_axis_tuser,   // opcode
    // result transfers
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // msg_number, msg_value, led_index,
                                                 // led_action, led_green, zero fill
    output logic [2:0]           m_axis_tuser,   // msg_kind
    output logic                 m_axis_tlast,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CALC = 4'b0100,
        ST_DEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [11:0] trig_reg;
    logic [7:0]  step_reg;
    logic [8:0]  smooth_reg;

    // item held for the whole read-modify-write
    logic                    opcode_reg;
    pkmsu_pkg::key_t         key_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;

    // shared key state
    logic [4:0]              active_reg;
    logic signed [6:0]       octave_reg;

    pkmsu_pkg::mem_ctl_t     mem_ctl;
    logic [SAMPLE_BITS-1:0]  rd_rest;
    pkmsu_pkg::key_state_t   rd_state;
    logic [SAMPLE_BITS-1:0]  wr_rest;
    pkmsu_pkg::key_state_t   wr_state;
    pkmsu_pkg::result_t      res0;
    pkmsu_pkg::result_t      res1;
    pkmsu_pkg::dec_t         dec;

    logic                    in_xfer;
    logic                    dec_fire;
    logic                    q_valid;
    pkmsu_pkg::result_t      q_head;
    logic                    q_last;
    logic                    cfg_wr;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // write back and push once the queue has room for this item's results
    assign dec_fire      = (state_reg == ST_DEC) && ((dec.count == 2'd0) || !q_valid);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_DEC;
            ST_DEC:  if (dec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= 5'd0;
            octave_reg <= 7'sd0;
        end else begin
            state_reg <= state_next;
            if (dec_fire) begin
                active_reg <= dec.active;
                octave_reg <= dec.octave;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            opcode_reg <= s_axis_tuser[0];
            key_reg    <= s_axis_tdata[pkmsu_pkg::KEY_W-1:0];
            sample_reg <= s_axis_tdata[pkmsu_pkg::KEY_W +: SAMPLE_BITS];
        end
    end

    // apb: no wait states, register index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg   <= pkmsu_pkg::TRIG_RESET;
            step_reg   <= pkmsu_pkg::STEP_RESET;
            smooth_reg <= pkmsu_pkg::SMOOTH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pkmsu_pkg::REG_TRIG:   trig_reg   <= pwdata[11:0];
                pkmsu_pkg::REG_STEP:   step_reg   <= pwdata[7:0];
                pkmsu_pkg::REG_SMOOTH: smooth_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pkmsu_pkg::REG_TRIG:   prdata = {20'd0, trig_reg};
            pkmsu_pkg::REG_STEP:   prdata = {24'd0, step_reg};
            pkmsu_pkg::REG_SMOOTH: prdata = {23'd0, smooth_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // memory read in ST_READ, write back on the decide cycle
    assign mem_ctl.rd   = (state_reg == ST_READ);
    assign mem_ctl.wr   = dec_fire;
    assign mem_ctl.addr = key_reg;

    pkmsu_state_mem #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .wr_rest  (wr_rest),
        .wr_state (wr_state),
        .rd_rest  (rd_rest),
        .rd_state (rd_state)
    );

    pkmsu_key_proc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_proc (
        .aclk     (aclk),
        .calc_en  (state_reg == ST_CALC),
        .opcode   (opcode_reg),
        .key      (key_reg),
        .sample   (sample_reg),
        .rest     (rd_rest),
        .st       (rd_state),
        .trig     (trig_reg),
        .step     (step_reg),
        .smooth_f (smooth_reg),
        .active   (active_reg),
        .octave   (octave_reg),
        .wr_rest  (wr_rest),
        .wr_state (wr_state),
        .res0     (res0),
        .res1     (res1),
        .dec      (dec)
    );

    pkmsu_out_q u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (dec_fire && (dec.count != 2'd0)),
        .count     (dec.count),
        .r0        (res0),
        .r1        (res1),
        .pop       (m_axis_tready),
        .valid     (q_valid),
        .head      (q_head),
        .head_last (q_last)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tlast  = q_last;
    assign m_axis_tuser  = q_head.kind;
    assign m_axis_tdata  = {3'd0, q_head.green, q_head.led_act, q_head.led_idx,
                            q_head.value, q_head.number};

endmodule

@@ hdl/pkmsu_checker.sv @@
// port-level checks of the pressure key scanner, bound to the top level
// depends on assert_macros.svh and pressure_key_midi_scanner_unit
`include "assert_macros.svh"

module pkmsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    `PKMSU_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // reset empties the result queue
    `PKMSU_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_axis_tvalid, "result offered after reset")

    // one item at a time: no new input right after a transfer
    `PKMSU_ASSERT(a_one_item, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while item in flight")

    // message kind and led code stay within their codes
    `PKMSU_ASSERT(a_kind_range, aclk, aresetn, m_axis_tvalid |-> (m_axis_tuser <= 3'd4) && (m_axis_tdata[20:18] <= 3'd5), "bad message or led code")

    // a result without last is followed by the rest of its item
    `PKMSU_ASSERT(a_last_pair, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "first of two results without a second")

endmodule

bind pressure_key_midi_scanner_unit pkmsu_checker u_pkmsu_checker (.*);
